// File: src/counting_semaphore_fifo_waiters_defines.svh
// Assertion macros shared by the semaphore RTL.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define CSFW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define CSFW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define CSFW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/csfw_pkg.sv
// Shared types, codes and defaults of the counting semaphore block.
package csfw_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 16;
   localparam int unsigned ID_WIDTH_DEF    = 8;
   localparam int unsigned COUNT_WIDTH_DEF = 16;

   localparam int unsigned ACTION_WIDTH  = 2;
   localparam int unsigned OUTCOME_WIDTH = 2;

   localparam logic [ACTION_WIDTH-1:0] ACT_ACQUIRE = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_CANCEL  = 2'd2;

   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_GRANTED  = 2'd0;
   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_QUEUED   = 2'd1;
   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_FAILED   = 2'd2;
   localparam logic [OUTCOME_WIDTH-1:0] OUTCOME_REJECTED = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      UNIT_PASS,
      UNIT_INC,
      UNIT_DEC
   } unit_op_type;

   typedef struct packed {
      logic is_zero;
      logic is_max;
   } unit_flags_type;

endpackage

// File: src/csfw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module csfw_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/csfw_unit.sv
// Shared saturating increment and decrement unit for the permit counter.
module csfw_unit #(
   parameter int unsigned WIDTH = 16
) (
   input  csfw_pkg::unit_op_type    op,
   input  logic [WIDTH-1:0]         operand,
   output logic [WIDTH-1:0]         result,
   output csfw_pkg::unit_flags_type flags
);
   import csfw_pkg::*;

   always_comb begin
      flags.is_zero = (operand == '0);
      flags.is_max  = (operand == '1);
      case (op)
         UNIT_INC: result = flags.is_max  ? operand : operand + WIDTH'(1);
         UNIT_DEC: result = flags.is_zero ? operand : operand - WIDTH'(1);
         default:  result = operand;
      endcase
   end

endmodule

// File: src/counting_semaphore_fifo_waiters.sv
// Top level of the counting semaphore with a first-in first-out waiter queue.
// Usage: requests arrive on the req_ channel (action, requester_id) and are
// taken when req_valid and req_ready are both high. Results leave on the
// rsp_ channel, one per handshake; rsp_last_of_run marks the final result of
// a request. An acquire gives one result, a release gives one result when it
// hands its permit to a waiter and none otherwise, and a cancel gives one
// failed result per queued waiter, oldest first. The csr_ channel loads the
// initial permit count and restarts the semaphore: pool reloaded, queue
// emptied, cancel flag cleared.
// Sequence: a request is taken in the idle state and then executed by the
// sequencer, which owns the one permit arithmetic unit and both queue RAM
// ports. An acquire, or a release with no waiter, passes through the idle
// and execute states; a release to a waiter also passes the emit state,
// because the queue RAM read is registered. A cancel walks its waiters,
// one RAM read and one result per cycle while the result register is free.
// Each result is registered and shows in the cycle after its state sets it.
// Reset loads one permit, clears the flag and empties the queue; no clearing
// pass is needed. A stalled receiver holds the result register, and the
// sequencer waits in place until the register can take the next result.
`include "counting_semaphore_fifo_waiters_defines.svh"

module counting_semaphore_fifo_waiters #(
   parameter int unsigned QUEUE_DEPTH = csfw_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned ID_WIDTH    = csfw_pkg::ID_WIDTH_DEF,
   parameter int unsigned COUNT_WIDTH = csfw_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [csfw_pkg::ACTION_WIDTH-1:0]  req_action,
   input  logic [ID_WIDTH-1:0]                req_requester_id,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ID_WIDTH-1:0]                rsp_target_id,
   output logic [csfw_pkg::OUTCOME_WIDTH-1:0] rsp_outcome,
   output logic [COUNT_WIDTH-1:0]             rsp_free_permits,
   output logic                               rsp_last_of_run,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [COUNT_WIDTH-1:0]             csr_data
);
   import csfw_pkg::*;

   // Index width of the queue RAM, occupancy width, and a width for head plus
   // occupancy before it wraps.
   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SW = OW + 1;

   state_type               state_ff, state_in;
   logic [ACTION_WIDTH-1:0] action_ff, action_in;
   logic [ID_WIDTH-1:0]     id_ff, id_in;
   logic [COUNT_WIDTH-1:0]  permit_ff, permit_in;
   logic                    cancel_ff, cancel_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [OW-1:0]           occ_ff, occ_in;
   logic                    drain_ff, drain_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ID_WIDTH-1:0]      rsp_id_ff, rsp_id_in;
   logic [OUTCOME_WIDTH-1:0] rsp_outcome_ff, rsp_outcome_in;
   logic [COUNT_WIDTH-1:0]   rsp_free_ff, rsp_free_in;
   logic                     rsp_last_ff, rsp_last_in;

   unit_op_type            unit_op;
   logic [COUNT_WIDTH-1:0] unit_result;
   unit_flags_type         unit_flags;

   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [ID_WIDTH-1:0] ram_rd_data;

   logic [SW-1:0] tail_sum;
   logic [SW-1:0] tail_wrap;
   logic [AW-1:0] tail_idx;
   logic [AW-1:0] head_next;
   logic          out_free;
   logic          csr_write;

   // The one arithmetic unit: every change of the permit pool goes through it.
   csfw_unit #(
      .WIDTH (COUNT_WIDTH)
   ) u_unit (
      .op      (unit_op),
      .operand (permit_ff),
      .result  (unit_result),
      .flags   (unit_flags)
   );

   // Waiter queue storage. Entries are only read inside the occupied range.
   csfw_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_idx),
      .wr_data (id_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The tail is head plus occupancy, wrapped once around the queue depth.
   assign tail_sum  = SW'(head_ff) + SW'(occ_ff);
   assign tail_wrap = (tail_sum >= SW'(QUEUE_DEPTH)) ? tail_sum - SW'(QUEUE_DEPTH) : tail_sum;
   assign tail_idx  = tail_wrap[AW-1:0];
   assign head_next = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);

   // The result register can take a new result when empty or being emptied.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         permit_ff    <= COUNT_WIDTH'(1);
         cancel_ff    <= 1'b0;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         permit_ff    <= permit_in;
         cancel_ff    <= cancel_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      id_ff          <= id_in;
      drain_ff       <= drain_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Sequencer: take a request, execute it against the pool and queue, then
   // for a hand-over or cancel, walk the queue one entry per unstalled cycle.
   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      id_in          = id_ff;
      permit_in      = permit_ff;
      cancel_in      = cancel_ff;
      head_in        = head_ff;
      occ_in         = occ_ff;
      drain_in       = drain_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_id_in      = rsp_id_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_last_in    = rsp_last_ff;
      req_ready      = 1'b0;
      unit_op        = UNIT_PASS;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = head_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in = req_action;
               id_in     = req_requester_id;
               state_in  = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
               case (action_ff)
                  ACT_ACQUIRE: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = id_ff;
                     rsp_free_in  = permit_ff;
                     rsp_last_in  = 1'b1;
                     if (cancel_ff) begin
                        rsp_outcome_in = OUTCOME_FAILED;
                     end else if (!unit_flags.is_zero) begin
                        unit_op        = UNIT_DEC;
                        permit_in      = unit_result;
                        rsp_free_in    = unit_result;
                        rsp_outcome_in = OUTCOME_GRANTED;
                     end else if (occ_ff < OW'(QUEUE_DEPTH)) begin
                        ram_wr_en      = 1'b1;
                        occ_in         = occ_ff + OW'(1);
                        rsp_outcome_in = OUTCOME_QUEUED;
                     end else begin
                        rsp_outcome_in = OUTCOME_REJECTED;
                     end
                  end
                  ACT_RELEASE: begin
                     if (!cancel_ff) begin
                        if (occ_ff != '0) begin
                           ram_rd_en = 1'b1;
                           drain_in  = 1'b0;
                           state_in  = ST_EMIT;
                        end else begin
                           unit_op   = UNIT_INC;
                           permit_in = unit_result;
                        end
                     end
                  end
                  ACT_CANCEL: begin
                     cancel_in = 1'b1;
                     if (occ_ff != '0) begin
                        ram_rd_en = 1'b1;
                        drain_in  = 1'b1;
                        state_in  = ST_EMIT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_EMIT: begin
            // The queue entry at the head is waiting in the RAM read register.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_id_in      = ram_rd_data;
               rsp_outcome_in = drain_ff ? OUTCOME_FAILED : OUTCOME_GRANTED;
               rsp_free_in    = permit_ff;
               rsp_last_in    = !drain_ff || (occ_ff == OW'(1));
               head_in        = head_next;
               occ_in         = occ_ff - OW'(1);
               if (drain_ff && (occ_ff != OW'(1))) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = head_next;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write restarts the semaphore.
      if (csr_write) begin
         permit_in = csr_data;
         cancel_in = 1'b0;
         head_in   = '0;
         occ_in    = '0;
         state_in  = ST_IDLE;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_id    = rsp_id_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_free_permits = rsp_free_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   `CSFW_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready && !csr_write, state_ff == ST_EXEC, "accepted request did not reach execute")
   `CSFW_ASSERT_IMPLY(a_emit_has_waiter, clock, reset, state_ff == ST_EMIT, occ_ff != '0, "queue walk with an empty queue")
   `CSFW_ASSERT_IMPLY(a_single_is_last, clock, reset, rsp_valid && (rsp_outcome != OUTCOME_FAILED), rsp_last_of_run, "single-result outcome not marked last")
   `CSFW_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= OW'(QUEUE_DEPTH), "queue occupancy beyond depth")

endmodule
